// ----- sv/crcse_pkg.sv -----
// Shared types and constants for the serial CRC encoder and checker.
// Used by the front end, the result sequencer and the top level.
`default_nettype none

package crcse_pkg;

  // Default largest generator degree the datapath is built for.
  localparam int DEFAULT_MAX_DEGREE = 32;

  // Width of the generator coefficient register.
  localparam int POLY_W = 32;

  // Width of the degree register.
  localparam int DEG_REG_W = 6;

  // Degree after reset.
  localparam logic [DEG_REG_W-1:0] GEN_DEGREE_RESET = 6'd8;

  // Depth of the command queue between the front end and the sequencer.
  localparam int CMDQ_DEPTH = 4;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEN_POLY   = 2'd0,
    REG_GEN_DEGREE = 2'd1,
    REG_OP_MODE    = 2'd2
  } cfg_reg_t;

  // Operating modes.
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_CHECK  = 1'b1
  } op_mode_t;

  // Per-item command flags handed from the front end to the sequencer.
  typedef struct packed {
    logic bit_val;   // data bit to emit when has_bit is set
    logic has_bit;   // the item yields a data result
    logic is_last;   // the item closes a message or codeword
    logic is_check;  // the item was taken in check mode
    logic ok;        // check status: remainder zero and length fine
    logic lerr;      // check status: codeword too short
  } cmd_flags_t;

endpackage

`default_nettype wire

// ----- sv/crcse_cmdq.sv -----
// Small register queue that carries commands from the front end to the sequencer.
// Depends on nothing but its parameters.
`default_nettype none

module crcse_cmdq #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = store[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("command queue count above depth");

  // The sequencer never takes a command from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty)
    else $error("command queue read while empty");

  // The front end never writes a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command queue written while full");

endmodule

`default_nettype wire

// ----- sv/crcse_front.sv -----
// Front end: configuration registers, input bit acceptance and the LFSR division step.
// Depends on crcse_pkg for register indexes, modes and the command flag struct.
`default_nettype none

module crcse_front #(
  parameter int MAX_DEGREE = crcse_pkg::DEFAULT_MAX_DEGREE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [crcse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crcse_pkg::POLY_W-1:0]        cfg_data,
  input  logic                                push,
  input  logic                                data_bit,
  input  logic                                last_bit,
  input  logic                                q_full,
  output logic                                cmd_push,
  output crcse_pkg::cmd_flags_t               cmd_flags,
  output logic [MAX_DEGREE-1:0]               cmd_rem,
  output logic [$clog2(MAX_DEGREE + 1)-1:0]   cmd_deg
);

  import crcse_pkg::*;

  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int CNT_W = $clog2(MAX_DEGREE + 2);
  localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  logic [POLY_W-1:0]     gen_poly;
  logic [DEG_REG_W-1:0]  gen_degree;
  op_mode_t              op_mode;

  logic [MAX_DEGREE-1:0] remainder_reg;
  logic [MAX_DEGREE-1:0] remainder_next;
  logic [MAX_DEGREE-1:0] delay_line;
  logic [MAX_DEGREE-1:0] delay_next;
  logic [CNT_W-1:0]      bit_count;
  logic [CNT_W-1:0]      bit_count_next;

  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] poly;
  logic [DEG_W-1:0]      deg;
  logic [IDX_W-1:0]      top_idx;
  logic                  top;
  logic                  accept;
  logic                  has_bit;
  logic                  lerr;
  logic                  ok;

  assign accept = push && !q_full;

  // Configuration writes; the port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_poly   <= '0;
      gen_degree <= GEN_DEGREE_RESET;
      op_mode    <= MODE_ENCODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GEN_POLY:   gen_poly   <= cfg_data;
        REG_GEN_DEGREE: gen_degree <= cfg_data[DEG_REG_W-1:0];
        REG_OP_MODE:    op_mode    <= op_mode_t'(cfg_data[0]);
        default:        ;
      endcase
    end
  end

  // Effective degree: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (gen_degree == '0) begin
      deg = DEG_W'(1);
    end else if (8'(gen_degree) > 8'(MAX_DEGREE)) begin
      deg = DEG_W'(MAX_DEGREE);
    end else begin
      deg = DEG_W'(gen_degree);
    end
  end

  // Degree mask and masked generator coefficients.
  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_bit
    assign mask[i] = (8'(i) < 8'(deg));
    if (i < POLY_W) begin : g_coef
      assign poly[i] = gen_poly[i] & mask[i];
    end else begin : g_zero
      assign poly[i] = 1'b0;
    end
  end

  assign top_idx = IDX_W'(deg - DEG_W'(1));
  assign top     = remainder_reg[top_idx];

  // One division step for the current mode.
  always_comb begin
    remainder_next = remainder_reg;
    delay_next     = delay_line;
    bit_count_next = bit_count;
    has_bit        = 1'b1;
    if (op_mode == MODE_ENCODE) begin
      remainder_next = ((remainder_reg << 1) & mask) ^ ((top ^ data_bit) ? poly : '0);
    end else begin
      remainder_next = ((remainder_reg << 1) | MAX_DEGREE'(data_bit)) & mask;
      remainder_next = remainder_next ^ (top ? poly : '0);
      delay_next     = ((delay_line << 1) | MAX_DEGREE'(data_bit)) & mask;
      has_bit        = (8'(bit_count) >= 8'(deg));
      if (8'(bit_count) <= 8'(MAX_DEGREE)) begin
        bit_count_next = bit_count + CNT_W'(1);
      end
    end
    lerr = (8'(bit_count_next) <= 8'(deg));
    ok   = !lerr && (remainder_next == '0);
  end

  // Stream state; a last bit clears it for the next codeword.
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder_reg <= '0;
      delay_line    <= '0;
      bit_count     <= '0;
    end else if (accept) begin
      if (last_bit) begin
        remainder_reg <= '0;
        delay_line    <= '0;
        bit_count     <= '0;
      end else begin
        remainder_reg <= remainder_next;
        delay_line    <= delay_next;
        bit_count     <= bit_count_next;
      end
    end
  end

  // Command for the sequencer; check-mode bits still filling the delay yield none.
  assign cmd_push           = accept && ((op_mode == MODE_ENCODE) || has_bit || last_bit);
  assign cmd_flags.bit_val  = (op_mode == MODE_ENCODE) ? data_bit : delay_line[top_idx];
  assign cmd_flags.has_bit  = has_bit;
  assign cmd_flags.is_last  = last_bit;
  assign cmd_flags.is_check = (op_mode == MODE_CHECK);
  assign cmd_flags.ok       = (op_mode == MODE_CHECK) && ok;
  assign cmd_flags.lerr     = (op_mode == MODE_CHECK) && lerr;
  assign cmd_rem            = remainder_next;
  assign cmd_deg            = deg;

endmodule

`default_nettype wire

// ----- sv/crcse_back.sv -----
// Result sequencer: expands queued commands into result beats and holds the output register.
// Depends on crcse_pkg for the command flag struct.
`default_nettype none

module crcse_back #(
  parameter int MAX_DEGREE = crcse_pkg::DEFAULT_MAX_DEGREE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  crcse_pkg::cmd_flags_t               head_flags,
  input  logic [MAX_DEGREE-1:0]               head_rem,
  input  logic [$clog2(MAX_DEGREE + 1)-1:0]   head_deg,
  output logic                                q_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic                                out_bit,
  output logic                                out_valid_bit,
  output logic                                out_last,
  output logic                                check_ok,
  output logic                                length_error
);

  import crcse_pkg::*;

  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  typedef enum logic [1:0] {
    P_START,
    P_REM,
    P_STAT
  } phase_t;

  phase_t                phase;
  phase_t                phase_next;
  logic [MAX_DEGREE-1:0] rem_hold;
  logic [MAX_DEGREE-1:0] rem_hold_next;
  logic [DEG_W-1:0]      rcnt;
  logic [DEG_W-1:0]      rcnt_next;
  logic                  out_full;
  logic                  adv;
  logic                  emit;
  logic                  done;
  logic                  res_bit;
  logic                  res_valid;
  logic                  res_last;
  logic                  res_ok;
  logic                  res_lerr;

  assign empty = !out_full;
  assign adv   = !out_full || pop;
  assign emit  = adv && !q_empty;
  assign q_pop = emit && done;

  // Next result beat from the head command.
  always_comb begin
    phase_next    = phase;
    rem_hold_next = rem_hold;
    rcnt_next     = rcnt;
    done          = 1'b0;
    res_bit       = 1'b0;
    res_valid     = 1'b0;
    res_last      = 1'b0;
    res_ok        = 1'b0;
    res_lerr      = 1'b0;
    case (phase)
      P_START: begin
        if (head_flags.has_bit) begin
          res_bit   = head_flags.bit_val;
          res_valid = 1'b1;
          if (!head_flags.is_last) begin
            done = 1'b1;
          end else if (head_flags.is_check) begin
            phase_next = P_STAT;
          end else begin
            phase_next    = P_REM;
            rem_hold_next = head_rem;
            rcnt_next     = head_deg;
          end
        end else begin
          res_last = 1'b1;
          res_ok   = head_flags.ok;
          res_lerr = head_flags.lerr;
          done     = 1'b1;
        end
      end
      P_REM: begin
        res_bit   = rem_hold[IDX_W'(rcnt - DEG_W'(1))];
        res_valid = 1'b1;
        res_last  = (rcnt == DEG_W'(1));
        rcnt_next = rcnt - DEG_W'(1);
        if (rcnt == DEG_W'(1)) begin
          done       = 1'b1;
          phase_next = P_START;
        end
      end
      P_STAT: begin
        res_last   = 1'b1;
        res_ok     = head_flags.ok;
        res_lerr   = head_flags.lerr;
        done       = 1'b1;
        phase_next = P_START;
      end
      default: begin
        phase_next = P_START;
      end
    endcase
  end

  // Sequencer state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_START;
      out_full <= 1'b0;
    end else begin
      if (adv) begin
        out_full <= emit;
      end
      if (emit) begin
        phase         <= phase_next;
        rem_hold      <= rem_hold_next;
        rcnt          <= rcnt_next;
        out_bit       <= res_bit;
        out_valid_bit <= res_valid;
        out_last      <= res_last;
        check_ok      <= res_ok;
        length_error  <= res_lerr;
      end
    end
  end

  // A command in progress stays at the head of the queue.
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (phase != P_START) |-> !q_empty)
    else $error("sequencer mid-command with empty queue");

  // The remainder flush never runs with nothing left to send.
  a_rcnt_live: assert property (@(posedge clk) disable iff (rst)
    (phase == P_REM) |-> (rcnt != '0))
    else $error("remainder flush with zero count");

  // A status beat always closes the codeword.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_valid_bit) |-> (out_last && !out_bit))
    else $error("status beat not marked last");

endmodule

`default_nettype wire

// ----- sv/crc_serial_encode_check.sv -----
// Top level of the serial CRC encoder and checker.
// Depends on crcse_pkg, crcse_front, crcse_cmdq and crcse_back.
`default_nettype none

// Serial CRC encoder/checker with a programmable generator x^d + gen_poly. Input bits are
// taken one per clock, most significant first, whenever full is low. In encode mode each
// bit comes back as one result beat and the last bit adds d remainder beats; in check mode
// the first d bits of a codeword produce no beat, later bits one each, and the last bit
// adds a status beat carrying check_ok and length_error. The front end does one division
// step per bit, so input accepts one bit per cycle while full is low; the sequencer sends
// one beat per cycle while commands wait and the output is empty or popped. An encode
// message of n bits yields n + d beats; a four-entry command queue lets input flow in the
// remainder flush until it fills. Results pass the command queue and output register.
// Configuration is always ready and must only be written while the block is idle.
module crc_serial_encode_check #(
  parameter int MAX_DEGREE = crcse_pkg::DEFAULT_MAX_DEGREE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crcse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crcse_pkg::POLY_W-1:0]    cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic                            data_bit,
  input  logic                            last_bit,
  input  logic                            pop,
  output logic                            empty,
  output logic                            out_bit,
  output logic                            out_valid_bit,
  output logic                            out_last,
  output logic                            check_ok,
  output logic                            length_error
);

  import crcse_pkg::*;

  localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int FLAG_W = $bits(cmd_flags_t);
  localparam int CMD_W  = FLAG_W + MAX_DEGREE + DEG_W;

  logic                  cmd_push;
  cmd_flags_t            cmd_flags;
  logic [MAX_DEGREE-1:0] cmd_rem;
  logic [DEG_W-1:0]      cmd_deg;
  logic [CMD_W-1:0]      q_wr_data;
  logic [CMD_W-1:0]      q_rd_data;
  logic                  q_empty;
  logic                  q_pop;
  cmd_flags_t            head_flags;
  logic [MAX_DEGREE-1:0] head_rem;
  logic [DEG_W-1:0]      head_deg;

  assign cfg_ready = 1'b1;

  // Front end: configuration and division.
  crcse_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .data_bit   (data_bit),
    .last_bit   (last_bit),
    .q_full     (full),
    .cmd_push   (cmd_push),
    .cmd_flags  (cmd_flags),
    .cmd_rem    (cmd_rem),
    .cmd_deg    (cmd_deg)
  );

  // Command queue between front end and sequencer.
  assign q_wr_data = {cmd_flags, cmd_rem, cmd_deg};
  assign {head_flags, head_rem, head_deg} = q_rd_data;

  crcse_cmdq #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (q_wr_data),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Result sequencer and output register.
  crcse_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head_flags    (head_flags),
    .head_rem      (head_rem),
    .head_deg      (head_deg),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_bit       (out_bit),
    .out_valid_bit (out_valid_bit),
    .out_last      (out_last),
    .check_ok      (check_ok),
    .length_error  (length_error)
  );

endmodule

`default_nettype wire
